@@ rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg: shared definitions for the modular exponentiation unit
// Field widths, the modulus reset value and the sizing of the shared
// multiply and reduce datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

   // Width of the base, the exponent, the modulus and the result fields.
   localparam int VALUE_WIDTH = 31;

   // Number of exponent bits scanned, from the most significant bit down.
   localparam int EXPONENT_WIDTH = 31;
   localparam int BIT_COUNT_WIDTH = $clog2(EXPONENT_WIDTH + 1);

   // Reset value of the modulus register.
   localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET = VALUE_WIDTH'(1000000007);

   // The double-width product is padded to a whole number of digits and
   // reduced one digit per cycle.
   localparam int DIGIT_BITS = 4;
   localparam int PRODUCT_WIDTH =
      ((2 * VALUE_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
   localparam int REDUCE_STEPS = PRODUCT_WIDTH / DIGIT_BITS;
   localparam int STEP_COUNT_WIDTH = $clog2(REDUCE_STEPS);

endpackage

`default_nettype wire

@@ rtl/mexp_channels.sv @@
// ----------------------------------------------------------------------------
// mexp_channels: valid/ready channels of the modular exponentiation unit
// The request channel carries a base and an exponent; the response channel
// carries the reduced power.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_req_if;
   logic                             valid;
   logic                             ready;
   logic [mexp_pkg::VALUE_WIDTH-1:0] base_value;
   logic [mexp_pkg::VALUE_WIDTH-1:0] exponent;

   modport source (output valid, output base_value, output exponent, input ready);
   modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mexp_pkg::VALUE_WIDTH-1:0] power_mod;

   modport source (output valid, output power_mod, input ready);
   modport sink   (input valid, input power_mod, output ready);
endinterface

`default_nettype wire

@@ rtl/modular_exponentiation_unit.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base to the exponent modulo a set modulus
// Square-and-multiply over the exponent bits, most significant bit first,
// with one multiplier and one digit-serial reduction unit shared by all steps.
// ----------------------------------------------------------------------------
// Usage:
//    An item on req_if brings base_value and exponent. The unit answers with
//    one item on rsp_if holding base_value ** exponent mod modulus. The
//    modulus is written through csr_write_enable / csr_write_data; write it
//    only while the unit is idle, as the unit does not enforce this. Reset
//    loads 1000000007. A modulus of 0 or 1 yields 0. The unit takes one
//    item at a time: req_if.ready is high only when no item is in work. The
//    first step reduces the base; then each of the 31 exponent bits costs
//    one squaring and, when the bit is set, one multiply by the base. A
//    multiply passes the 31x31 multiplier, then the reduction unit, which
//    retires four product bits per cycle. With a modulus below 2 an item
//    goes straight to the finish state. The result sits in an output
//    register; a new item is accepted while it waits, and if the next
//    result finishes before rsp_if.ready, the unit holds it until the
//    output register frees. Reset drops any item in work or waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_unit (
   input  wire                             clock,
   input  wire                             reset,
   mexp_req_if.sink                        req_if,
   mexp_rsp_if.source                      rsp_if,
   input  wire                             csr_write_enable,
   input  wire [mexp_pkg::VALUE_WIDTH-1:0] csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULTIPLY,
      ST_REDUCE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_BASE,
      OP_SQUARE,
      OP_TIMES_BASE
   } op_type;

   state_type                                state_ff;
   op_type                                   op_ff;
   logic [mexp_pkg::VALUE_WIDTH-1:0]         modulus_ff;
   logic [mexp_pkg::VALUE_WIDTH-1:0]         work_mod_ff;
   logic [mexp_pkg::VALUE_WIDTH-1:0]         base_ff;
   logic [mexp_pkg::VALUE_WIDTH-1:0]         acc_ff;
   logic [mexp_pkg::VALUE_WIDTH-1:0]         rem_ff;
   logic [mexp_pkg::VALUE_WIDTH-1:0]         rem_in;
   logic [mexp_pkg::PRODUCT_WIDTH-1:0]       prod_ff;
   logic [2*mexp_pkg::VALUE_WIDTH-1:0]       mult_result;
   logic [mexp_pkg::VALUE_WIDTH-1:0]         mult_operand;
   logic [mexp_pkg::EXPONENT_WIDTH-1:0]      exp_ff;
   logic [mexp_pkg::BIT_COUNT_WIDTH-1:0]     bit_cnt_ff;
   logic [mexp_pkg::STEP_COUNT_WIDTH-1:0]    step_cnt_ff;
   logic                                     rsp_valid_ff;
   logic [mexp_pkg::VALUE_WIDTH-1:0]         rsp_power_mod_ff;
   logic                                     req_accept;
   logic                                     last_step;

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign req_accept       = req_if.valid && req_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.power_mod = rsp_power_mod_ff;
   assign last_step        = (step_cnt_ff ==
                              mexp_pkg::STEP_COUNT_WIDTH'(mexp_pkg::REDUCE_STEPS - 1));

   // Shared multiplier: squares the accumulator or multiplies it by the base.
   assign mult_operand = (op_ff == OP_SQUARE) ? acc_ff : base_ff;
   assign mult_result  = acc_ff * mult_operand;

   // Reduction unit: shifts the next product digit into the remainder, one
   // bit at a time, subtracting the modulus whenever the remainder reaches it.
   always_comb begin
      logic [mexp_pkg::VALUE_WIDTH:0] trial;
      logic [mexp_pkg::VALUE_WIDTH:0] rem_wide;
      rem_in = rem_ff;
      for (int i = 0; i < mexp_pkg::DIGIT_BITS; i++) begin
         trial    = {rem_in, prod_ff[mexp_pkg::PRODUCT_WIDTH-1-i]};
         rem_wide = (trial >= {1'b0, work_mod_ff}) ? (trial - {1'b0, work_mod_ff}) : trial;
         rem_in   = rem_wide[mexp_pkg::VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_BASE;
         modulus_ff   <= mexp_pkg::MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            modulus_ff <= csr_write_data;
         end
         if ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  work_mod_ff <= modulus_ff;
                  exp_ff      <= mexp_pkg::EXPONENT_WIDTH'(req_if.exponent);
                  prod_ff     <= mexp_pkg::PRODUCT_WIDTH'(req_if.base_value);
                  rem_ff      <= '0;
                  step_cnt_ff <= '0;
                  op_ff       <= OP_BASE;
                  if (modulus_ff < mexp_pkg::VALUE_WIDTH'(2)) begin
                     acc_ff   <= '0;
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_REDUCE;
                  end
               end
            end

            ST_MULTIPLY: begin
               prod_ff     <= mexp_pkg::PRODUCT_WIDTH'(mult_result);
               rem_ff      <= '0;
               step_cnt_ff <= '0;
               state_ff    <= ST_REDUCE;
            end

            ST_REDUCE: begin
               rem_ff      <= rem_in;
               prod_ff     <= prod_ff << mexp_pkg::DIGIT_BITS;
               step_cnt_ff <= step_cnt_ff + 1'b1;
               if (last_step) begin
                  case (op_ff)
                     OP_BASE: begin
                        base_ff    <= rem_in;
                        acc_ff     <= mexp_pkg::VALUE_WIDTH'(1);
                        bit_cnt_ff <= mexp_pkg::BIT_COUNT_WIDTH'(mexp_pkg::EXPONENT_WIDTH - 1);
                        op_ff      <= OP_SQUARE;
                        state_ff   <= ST_MULTIPLY;
                     end
                     OP_SQUARE: begin
                        acc_ff <= rem_in;
                        if (exp_ff[mexp_pkg::EXPONENT_WIDTH-1]) begin
                           op_ff    <= OP_TIMES_BASE;
                           state_ff <= ST_MULTIPLY;
                        end else if (bit_cnt_ff == '0) begin
                           state_ff <= ST_FINISH;
                        end else begin
                           bit_cnt_ff <= bit_cnt_ff - 1'b1;
                           exp_ff     <= exp_ff << 1;
                           state_ff   <= ST_MULTIPLY;
                        end
                     end
                     OP_TIMES_BASE: begin
                        acc_ff <= rem_in;
                        op_ff  <= OP_SQUARE;
                        if (bit_cnt_ff == '0) begin
                           state_ff <= ST_FINISH;
                        end else begin
                           bit_cnt_ff <= bit_cnt_ff - 1'b1;
                           exp_ff     <= exp_ff << 1;
                           state_ff   <= ST_MULTIPLY;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end

            ST_FINISH: begin
               // The result waits here until the output register is free.
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_power_mod_ff <= acc_ff;
                  state_ff         <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // The partial remainder never reaches the modulus in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE) |-> (rem_ff < work_mod_ff))
      else $error("reduction remainder not below modulus");

   // The accumulator and the base are reduced before they enter the multiplier.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULTIPLY) |-> (acc_ff < work_mod_ff && base_ff < work_mod_ff))
      else $error("multiplier operand not reduced");

   // A finished result is below the modulus, or zero for a degenerate modulus.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (acc_ff < work_mod_ff || acc_ff == '0))
      else $error("result out of range");

   // An accepted item keeps the unit busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_if.ready)
      else $error("request accepted while busy");

endmodule

`default_nettype wire
